>>> rtl/sitbd_pkg.sv
// sitbd_pkg: shared types, constants and the symbol lookup for the
// signed integer to base digits converter. No dependencies.
package sitbd_pkg;

  localparam int CFG_ADDR_W  = 5;
  localparam int CFG_DATA_W  = 64;
  localparam int BASE_SIZE_W = 5;
  localparam int SYMBOL_W    = 8;
  localparam int SYM_DIGIT_W = 4;
  localparam int ALPHABET_W  = 128;

  // register index, taken from paddr[4:3]
  localparam logic [1:0] REG_BASE_SIZE     = 2'd0;
  localparam logic [1:0] REG_ALPHABET_LOW  = 2'd1;
  localparam logic [1:0] REG_ALPHABET_HIGH = 2'd2;

  localparam logic [BASE_SIZE_W-1:0] BASE_SIZE_RESET     = 5'd10;
  localparam logic [CFG_DATA_W-1:0]  ALPHABET_LOW_RESET  = 64'h3736353433323130;
  localparam logic [CFG_DATA_W-1:0]  ALPHABET_HIGH_RESET = 64'h0000000000003938;

  localparam logic [SYMBOL_W-1:0] MINUS_SIGN = 8'h2D;

  typedef struct packed {
    logic                   load;
    logic                   neg;
    logic                   push;
    logic [SYM_DIGIT_W-1:0] digit;
    logic                   flush;
  } emit_ctrl_t;

  function automatic logic [SYMBOL_W-1:0] sym_lookup(
    input logic [ALPHABET_W-1:0]  alphabet,
    input logic [SYM_DIGIT_W-1:0] digit
  );
    sym_lookup = alphabet[{digit, 3'b000} +: SYMBOL_W];
  endfunction

endpackage

>>> rtl/sitbd_cfg.sv
// sitbd_cfg: APB-style register file for radix and alphabet, with radix clamp.
// Depends on sitbd_pkg.
module sitbd_cfg #(
  parameter int MAX_RADIX = 16,
  parameter int RADIX_W   = 5
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [sitbd_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [sitbd_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [sitbd_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                 pready,
  output logic [RADIX_W-1:0]                   radix,
  output logic [sitbd_pkg::ALPHABET_W-1:0]     alphabet
);
  import sitbd_pkg::*;

  logic [BASE_SIZE_W-1:0] base_size;
  logic [CFG_DATA_W-1:0]  alphabet_low;
  logic [CFG_DATA_W-1:0]  alphabet_high;
  logic [1:0]             reg_idx;
  logic                   wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr      = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_size     <= BASE_SIZE_RESET;
      alphabet_low  <= ALPHABET_LOW_RESET;
      alphabet_high <= ALPHABET_HIGH_RESET;
    end else if (wr) begin
      case (reg_idx)
        REG_BASE_SIZE:     base_size     <= pwdata[BASE_SIZE_W-1:0];
        REG_ALPHABET_LOW:  alphabet_low  <= pwdata;
        REG_ALPHABET_HIGH: alphabet_high <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BASE_SIZE:     prdata = CFG_DATA_W'(base_size);
      REG_ALPHABET_LOW:  prdata = alphabet_low;
      REG_ALPHABET_HIGH: prdata = alphabet_high;
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    if (base_size < BASE_SIZE_W'(2)) begin
      radix = RADIX_W'(2);
    end else if (base_size > BASE_SIZE_W'(MAX_RADIX)) begin
      radix = RADIX_W'(MAX_RADIX);
    end else begin
      radix = RADIX_W'(base_size);
    end
  end

  assign alphabet = {alphabet_high, alphabet_low};

endmodule

>>> rtl/sitbd_div.sv
// sitbd_div: bit-serial restoring divider by a small radix, one quotient bit
// per cycle; the quotient stays in place for the next digit. No dependencies.
module sitbd_div #(
  parameter int VALUE_BITS = 32,
  parameter int RADIX_W    = 5,
  parameter int REM_W      = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic [VALUE_BITS-1:0] mag,
  input  logic                  run,
  input  logic [RADIX_W-1:0]    radix,
  output logic                  done,
  output logic [REM_W-1:0]      digit,
  output logic                  quot_nz
);

  localparam int CNT_W = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] quot;
  logic [REM_W-1:0]      rem;
  logic [CNT_W-1:0]      cnt;
  logic                  nz;
  logic [REM_W:0]        trial;
  logic [REM_W:0]        divisor;
  logic                  ge;
  logic [REM_W-1:0]      rem_next;

  assign trial    = {rem, quot[VALUE_BITS-1]};
  assign divisor  = (REM_W+1)'(radix);
  assign ge       = trial >= divisor;
  assign rem_next = ge ? REM_W'(trial - divisor) : REM_W'(trial);
  assign done     = run && (cnt == CNT_W'(VALUE_BITS - 1));
  assign digit    = rem_next;
  assign quot_nz  = nz || ge;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      nz  <= 1'b0;
      rem <= '0;
    end else if (load) begin
      cnt <= '0;
      nz  <= 1'b0;
      rem <= '0;
    end else if (run) begin
      if (done) begin
        cnt <= '0;
        nz  <= 1'b0;
        rem <= '0;
      end else begin
        cnt <= cnt + CNT_W'(1);
        nz  <= quot_nz;
        rem <= rem_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      quot <= mag;
    end else if (run) begin
      quot <= {quot[VALUE_BITS-2:0], ge};
    end
  end

endmodule

>>> rtl/sitbd_emit.sv
// sitbd_emit: digit stack (shift register, last pushed on top), sign flag and
// output register with symbol lookup. Depends on sitbd_pkg.
module sitbd_emit #(
  parameter int VALUE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  sitbd_pkg::emit_ctrl_t             ctrl,
  input  logic [sitbd_pkg::ALPHABET_W-1:0]  alphabet,
  output logic                              busy,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sitbd_pkg::SYMBOL_W-1:0]    symbol,
  output logic                              last
);
  import sitbd_pkg::*;

  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  logic [SYM_DIGIT_W-1:0] stack [VALUE_BITS];
  logic [CNT_W-1:0]       count;
  logic                   sign_pend;
  logic                   step;
  logic                   pop;

  assign busy = sign_pend || (count != '0);
  assign step = ctrl.flush && (!out_valid || !out_stall) && busy;
  assign pop  = step && !sign_pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      count     <= '0;
      sign_pend <= 1'b0;
    end else begin
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (ctrl.load) begin
        sign_pend <= ctrl.neg;
      end else if (step && sign_pend) begin
        sign_pend <= 1'b0;
      end
      if (ctrl.push) begin
        count <= count + CNT_W'(1);
      end else if (pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (sign_pend) begin
        symbol <= MINUS_SIGN;
        last   <= 1'b0;
      end else begin
        symbol <= sym_lookup(alphabet, stack[0]);
        last   <= (count == CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      stack[0] <= ctrl.digit;
      for (int i = 1; i < VALUE_BITS; i++) begin
        stack[i] <= stack[i-1];
      end
    end else if (pop) begin
      for (int i = 0; i < VALUE_BITS - 1; i++) begin
        stack[i] <= stack[i+1];
      end
    end
  end

endmodule

>>> rtl/signed_int_to_base_digits_top.sv
// signed_int_to_base_digits_top: converts a signed integer to radix text,
// one character per output request. Uses sitbd_pkg, sitbd_cfg, sitbd_div, sitbd_emit.
//
//   channel | signals                                   | carries
//   in      | in_valid, in_stall, value                 | one integer per request
//   out     | out_valid, out_stall, symbol, last        | one character per request
//   cfg     | psel, penable, pwrite, paddr, pwdata, ... | base_size, alphabet_low/high
//
// one item goes through serial division, one digit per pass over all VALUE_BITS bits,
// then one character per output step, then the handoff back to idle.
// the divider retires one quotient bit per cycle; that loop sets the rate.
// a new item is taken once the previous text has been moved to the output register;
// out_stall on a waiting character holds the output and so delays the next item.
// in_stall is high during reset, which restores radix 10 and the "0123456789" alphabet.
module signed_int_to_base_digits_top #(
  parameter int MAX_RADIX  = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [VALUE_BITS-1:0]      value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [sitbd_pkg::SYMBOL_W-1:0]    symbol,
  output logic                              last,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [sitbd_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [sitbd_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [sitbd_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                              pready
);
  import sitbd_pkg::*;

  localparam int RADIX_W = $clog2(MAX_RADIX + 1);
  localparam int REM_W   = $clog2(MAX_RADIX);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [RADIX_W-1:0]    radix;
  logic [ALPHABET_W-1:0] alphabet;
  logic                  accept;
  logic                  negative;
  logic [VALUE_BITS-1:0] mag;
  logic                  div_run;
  logic                  div_done;
  logic [REM_W-1:0]      div_digit;
  logic                  quot_nz;
  logic                  emit_busy;
  emit_ctrl_t            ctrl;

  assign in_stall = rst || (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign negative = value[VALUE_BITS-1];
  assign mag      = negative ? VALUE_BITS'(-value) : VALUE_BITS'(value);
  assign div_run  = (state == ST_DIV);

  always_comb begin
    ctrl.load  = accept;
    ctrl.neg   = negative;
    ctrl.push  = div_done;
    ctrl.digit = SYM_DIGIT_W'(div_digit);
    ctrl.flush = (state == ST_EMIT);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_DIV;
      ST_DIV:  if (div_done && !quot_nz) state_next = ST_EMIT;
      ST_EMIT: if (!emit_busy) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  sitbd_cfg #(
    .MAX_RADIX (MAX_RADIX),
    .RADIX_W   (RADIX_W)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .radix    (radix),
    .alphabet (alphabet)
  );

  sitbd_div #(
    .VALUE_BITS (VALUE_BITS),
    .RADIX_W    (RADIX_W),
    .REM_W      (REM_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .load    (accept),
    .mag     (mag),
    .run     (div_run),
    .radix   (radix),
    .done    (div_done),
    .digit   (div_digit),
    .quot_nz (quot_nz)
  );

  sitbd_emit #(
    .VALUE_BITS (VALUE_BITS)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .alphabet  (alphabet),
    .busy      (emit_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .symbol    (symbol),
    .last      (last)
  );

endmodule
